### rtl/core/cei_pkg.sv
// ----------------------------------------------------------------------------
// cei_pkg
// Shared types and constants of the cubic ease-in generator: register
// indexes, the sequencer state type and the engine control/status groups.
// ----------------------------------------------------------------------------
package cei_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END      = 2'd2;

    // duration after reset, in ticks
    localparam int DUR_RESET = 60;

    // engine sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P2,
        ST_MUL_P3,
        ST_MUL_D2,
        ST_MUL_D3,
        ST_DBL,
        ST_ADD,
        ST_DONE
    } t_eng_state;

    // top level to engine
    typedef struct packed {
        logic start;
        logic is_end;
        logic take;
    } t_eng_ctrl;

    // engine to top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;

endpackage

### rtl/core/cubic_ease_in_generator.sv
// ----------------------------------------------------------------------------
// cubic_ease_in_generator
// Per tick, emits start + (end - start) * p^3 / d^3 truncated toward zero,
// then advances the step counter p until it reaches the duration d.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. The block takes one tick at a
// time: a tick that is not at the end of the ease steps through the states
// MUL_P2, MUL_P3, MUL_D2 and MUL_D3 on one shared multiplier for p^3 and d^3,
// then through the serial remainder loop, one add-and-reduce per cycle on one
// shared unit, to a valid result; a tick at or past the duration goes straight
// to its result. The result sits in an output register, so the next tick is
// accepted while it waits to be taken.
// Configuration writes land at once and must only be made while idle.
// ----------------------------------------------------------------------------
module cubic_ease_in_generator #(
    parameter int VALUE_BITS = 16,
    parameter int STEP_BITS  = 12
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // configuration
    input  logic                                       i_cfg_we,
    input  logic [cei_pkg::CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [((VALUE_BITS > STEP_BITS) ? VALUE_BITS : STEP_BITS)-1:0]
                                                       i_cfg_data,
    // tick input
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic                                       i_restart,
    // result output
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic signed [VALUE_BITS-1:0]               o_eased_value,
    output logic [STEP_BITS-1:0]                       o_step_used,
    output logic                                       o_finished
);
    import cei_pkg::*;

    localparam logic [STEP_BITS-1:0] DUR_RST = STEP_BITS'(DUR_RESET);

    logic [STEP_BITS-1:0]  r_dur;
    logic [VALUE_BITS-1:0] r_start;
    logic [VALUE_BITS-1:0] r_end_val;
    logic [STEP_BITS-1:0]  r_step, n_step;
    logic [STEP_BITS-1:0]  r_p;
    logic                  r_fin;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;
    logic [STEP_BITS-1:0]  r_out_step;
    logic                  r_out_fin;

    logic [STEP_BITS-1:0]  p_sel;
    logic [STEP_BITS-1:0]  p_clip;
    logic                  is_end;
    logic                  accept;
    logic                  slot_free;
    logic                  load;
    logic [VALUE_BITS-1:0] eng_value;
    t_eng_ctrl             s_ctrl;
    t_eng_stat             s_stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur     <= DUR_RST;
            r_start   <= '0;
            r_end_val <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DURATION: r_dur     <= i_cfg_data[STEP_BITS-1:0];
                CFG_START:    r_start   <= i_cfg_data[VALUE_BITS-1:0];
                CFG_END:      r_end_val <= i_cfg_data[VALUE_BITS-1:0];
                default:      r_dur     <= r_dur;
            endcase
        end
    end

    // step selection: restart, then clip to the duration
    assign p_sel  = i_restart ? '0 : r_step;
    assign p_clip = (p_sel > r_dur) ? r_dur : p_sel;
    assign is_end = (p_clip == r_dur);
    assign n_step = is_end ? p_clip : (p_clip + STEP_BITS'(1));

    // handshake
    assign o_ready   = s_stat.idle;
    assign accept    = i_valid && o_ready;
    assign slot_free = !r_out_valid || i_ready;
    assign load      = s_stat.done && slot_free;

    assign s_ctrl.start  = accept;
    assign s_ctrl.is_end = is_end;
    assign s_ctrl.take   = slot_free;

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (accept) begin
            r_step <= n_step;
        end
    end

    // per-transaction step and finished flag
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p   <= p_clip;
            r_fin <= is_end;
        end
    end

    cei_engine #(
        .VALUE_BITS (VALUE_BITS),
        .STEP_BITS  (STEP_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (s_ctrl),
        .i_step        (p_clip),
        .i_dur         (r_dur),
        .i_start_value (r_start),
        .i_end_value   (r_end_val),
        .o_stat        (s_stat),
        .o_value       (eng_value)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_value <= eng_value;
            r_out_step  <= r_p;
            r_out_fin   <= r_fin;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_eased_value = r_out_value;
    assign o_step_used   = r_out_step;
    assign o_finished    = r_out_fin;

    // an accepted tick makes the engine busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_stat.idle)
        else $error("engine still idle after an accepted transaction");

    // the counter never passes the duration
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_step <= $past(r_dur)))
        else $error("step counter beyond duration");

    // a finished result lands in a free output register
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_out_valid)
        else $error("finished result not presented");

endmodule

### rtl/core/cei_addred.sv
// ----------------------------------------------------------------------------
// cei_addred
// Shared add-and-reduce unit: y = (a + b) mod den for a, b below den, with
// a flag telling whether the reduction took place.
// ----------------------------------------------------------------------------
module cei_addred #(
    parameter int RW = 36
) (
    input  logic [RW-1:0] i_a,
    input  logic [RW-1:0] i_b,
    input  logic [RW-1:0] i_den,
    output logic [RW-1:0] o_y,
    output logic          o_ge
);

    logic [RW:0] sum;
    logic [RW:0] diff;

    // one add, one compare and subtract
    assign sum  = {1'b0, i_a} + {1'b0, i_b};
    assign diff = sum - {1'b0, i_den};
    assign o_ge = (sum >= {1'b0, i_den});
    assign o_y  = o_ge ? diff[RW-1:0] : sum[RW-1:0];

endmodule

### rtl/core/cei_engine.sv
// ----------------------------------------------------------------------------
// cei_engine
// Iterative engine: forms p^3 and d^3 on one shared multiplier, then walks
// the span magnitude bit by bit through the add-and-reduce unit to get
// floor(|span| * p^3 / d^3), and adds or subtracts it from the start value.
// ----------------------------------------------------------------------------
module cei_engine #(
    parameter int VALUE_BITS = 16,
    parameter int STEP_BITS  = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cei_pkg::t_eng_ctrl     i_ctrl,
    input  logic [STEP_BITS-1:0]   i_step,
    input  logic [STEP_BITS-1:0]   i_dur,
    input  logic [VALUE_BITS-1:0]  i_start_value,
    input  logic [VALUE_BITS-1:0]  i_end_value,
    output cei_pkg::t_eng_stat     o_stat,
    output logic [VALUE_BITS-1:0]  o_value
);
    import cei_pkg::*;

    localparam int QW = VALUE_BITS + 1;
    localparam int RW = 3 * STEP_BITS;
    localparam int MW = 2 * STEP_BITS;
    localparam int BW = $clog2(QW);

    t_eng_state r_state, n_state;

    logic [RW-1:0]        r_num, n_num;
    logic [RW-1:0]        r_den, n_den;
    logic [RW-1:0]        r_rem, n_rem;
    logic [QW-1:0]        r_q, n_q;
    logic [QW-1:0]        r_mag, n_mag;
    logic                 r_neg, n_neg;
    logic                 r_end, n_end;
    logic [BW-1:0]        r_bit, n_bit;
    logic [STEP_BITS-1:0] r_p, n_p;

    logic [MW-1:0]        mul_a;
    logic [STEP_BITS-1:0] mul_b;
    logic [RW-1:0]        mul_y;
    logic [RW-1:0]        au_b;
    logic [RW-1:0]        au_y;
    logic                 au_ge;
    logic [QW-1:0]        span;
    logic [QW-1:0]        base;
    logic [QW-1:0]        sum;
    logic                 last_bit;

    // shared multiplier, 2*STEP_BITS by STEP_BITS
    assign mul_y = {{STEP_BITS{1'b0}}, mul_a} * {{MW{1'b0}}, mul_b};

    // shared add-and-reduce unit
    cei_addred #(
        .RW (RW)
    ) u_addred (
        .i_a   (r_rem),
        .i_b   (au_b),
        .i_den (r_den),
        .o_y   (au_y),
        .o_ge  (au_ge)
    );

    // span and result
    assign span     = {i_end_value[VALUE_BITS-1], i_end_value}
                    - {i_start_value[VALUE_BITS-1], i_start_value};
    assign base     = {i_start_value[VALUE_BITS-1], i_start_value};
    assign sum      = r_neg ? (base - r_q) : (base + r_q);
    assign o_value  = r_end ? i_end_value : sum[VALUE_BITS-1:0];
    assign last_bit = (r_bit == BW'(QW - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_ctrl.start) begin
                    n_state = i_ctrl.is_end ? ST_DONE : ST_MUL_P2;
                end
            end
            ST_MUL_P2: n_state = ST_MUL_P3;
            ST_MUL_P3: n_state = ST_MUL_D2;
            ST_MUL_D2: n_state = ST_MUL_D3;
            ST_MUL_D3: n_state = ST_DBL;
            ST_DBL: begin
                if (r_mag[QW-1]) begin
                    n_state = ST_ADD;
                end else if (last_bit) begin
                    n_state = ST_DONE;
                end
            end
            ST_ADD: begin
                n_state = last_bit ? ST_DONE : ST_DBL;
            end
            ST_DONE: begin
                if (i_ctrl.take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and operand selection
    always_comb begin
        o_stat = '0;
        mul_a  = '0;
        mul_b  = '0;
        au_b   = r_rem;
        unique case (r_state)
            ST_IDLE:   o_stat.idle = 1'b1;
            ST_MUL_P2: begin
                mul_a = {{STEP_BITS{1'b0}}, r_p};
                mul_b = r_p;
            end
            ST_MUL_P3: begin
                mul_a = r_num[MW-1:0];
                mul_b = r_p;
            end
            ST_MUL_D2: begin
                mul_a = {{STEP_BITS{1'b0}}, i_dur};
                mul_b = i_dur;
            end
            ST_MUL_D3: begin
                mul_a = r_den[MW-1:0];
                mul_b = i_dur;
            end
            ST_DBL:    au_b = r_rem;
            ST_ADD:    au_b = r_num;
            ST_DONE:   o_stat.done = 1'b1;
            default:   o_stat = '0;
        endcase
    end

    // datapath next values
    always_comb begin
        n_num = r_num;
        n_den = r_den;
        n_rem = r_rem;
        n_q   = r_q;
        n_mag = r_mag;
        n_neg = r_neg;
        n_end = r_end;
        n_bit = r_bit;
        n_p   = r_p;
        unique case (r_state)
            ST_IDLE: begin
                if (i_ctrl.start) begin
                    n_p   = i_step;
                    n_end = i_ctrl.is_end;
                    n_neg = span[QW-1];
                    n_mag = span[QW-1] ? (~span + QW'(1)) : span;
                    n_rem = '0;
                    n_q   = '0;
                    n_bit = '0;
                end
            end
            ST_MUL_P2, ST_MUL_P3: n_num = mul_y;
            ST_MUL_D2, ST_MUL_D3: n_den = mul_y;
            // double the remainder, shift in a quotient bit
            ST_DBL: begin
                n_rem = au_y;
                n_q   = {r_q[QW-2:0], au_ge};
                n_mag = r_mag << 1;
                if (!r_mag[QW-1]) begin
                    n_bit = r_bit + BW'(1);
                end
            end
            // add p^3 for a set magnitude bit
            ST_ADD: begin
                n_rem = au_y;
                n_q   = r_q + QW'(au_ge);
                n_bit = r_bit + BW'(1);
            end
            ST_DONE: n_p = r_p;
            default: n_p = r_p;
        endcase
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_mag <= n_mag;
        r_neg <= n_neg;
        r_end <= n_end;
        r_bit <= n_bit;
        r_p   <= n_p;
    end

endmodule
